// ----- sv/lsd_pkg.sv -----
// Shared constants, word type and reciprocal table for the Legendre series density pipeline.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lsd_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAX_TERMS  = 6;
    localparam int NUM_COEFS  = 6;
    localparam int RECIP_BITS = 30;

    localparam int U_W     = 17;
    localparam int COEF_W  = 24;
    localparam int SCALE_W = 24;
    localparam int CFG_W   = 24;
    localparam int CFG_A_W = 3;
    localparam int TC_W    = 3;
    localparam int DEN_W   = 32;

    localparam int T_W    = FRAC_BITS + 2;
    localparam int P_W    = FRAC_BITS + 4;
    localparam int TP_W   = T_W + P_W;
    localparam int NUM_W  = TP_W + 5;
    localparam int N1_W   = NUM_W - FRAC_BITS;
    localparam int RC_W   = RECIP_BITS + 1;
    localparam int MR_W   = N1_W + RC_W + 1;
    localparam int CP_W   = COEF_W + P_W;
    localparam int ACC_W  = 2 * FRAC_BITS + 17;
    localparam int SHP_W  = ACC_W - FRAC_BITS - 1;
    localparam int PRD_W  = SHP_W + SCALE_W;

    // register map
    localparam logic [CFG_A_W-1:0] REG_TERM_COUNT = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_SCALE      = 3'd7;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic                    last;
        logic signed [T_W-1:0]   t;
        logic signed [P_W-1:0]   p0;
        logic signed [P_W-1:0]   p1;
        logic signed [ACC_W-1:0] acc;
    } t_item;

    // round(2^30 / r)
    function automatic logic [RC_W-1:0] recip(input logic [TC_W-1:0] r);
        logic [RC_W-1:0] v;
        begin
            case (r)
                3'd1:    v = RC_W'(64'd1073741824);
                3'd2:    v = RC_W'(64'd536870912);
                3'd3:    v = RC_W'(64'd357913941);
                3'd4:    v = RC_W'(64'd268435456);
                3'd5:    v = RC_W'(64'd214748365);
                3'd6:    v = RC_W'(64'd178956971);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// ----- sv/lsd_front.sv -----
// Input stage: clamps the point, forms t = 2u - 1 and seeds the recurrence and the sum.
// Depends on lsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsd_front (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_ready,
    input  wire  [lsd_pkg::U_W-1:0]    i_u_point,
    input  wire                        i_last_in,
    output logic                       o_valid,
    input  wire                        i_ready,
    output lsd_pkg::t_item             o_item
);

    localparam logic [lsd_pkg::U_W-1:0] ONE_U = lsd_pkg::U_W'(1) << lsd_pkg::FRAC_BITS;

    logic                              r_vld;
    lsd_pkg::t_item                    r_item;
    lsd_pkg::t_item                    n_item;
    logic                              w_en;
    logic [lsd_pkg::U_W-1:0]           w_u;
    logic signed [lsd_pkg::T_W:0]      w_t_wide;

    assign w_en    = !r_vld || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_comb begin
        w_u      = (i_u_point > ONE_U) ? ONE_U : i_u_point;
        w_t_wide = $signed({1'b0, w_u, 1'b0}) - $signed((lsd_pkg::T_W + 1)'(ONE_U));
        n_item.last = i_last_in;
        n_item.t    = w_t_wide[lsd_pkg::T_W-1:0];
        n_item.p0   = lsd_pkg::P_W'(1) << lsd_pkg::FRAC_BITS;
        n_item.p1   = lsd_pkg::P_W'(n_item.t);
        n_item.acc  = lsd_pkg::ACC_W'(1) << (2 * lsd_pkg::FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// ----- sv/lsd_term.sv -----
// One recurrence step: P_r from P_(r-1), P_(r-2), and adds coef_(r-1) * P_(r-1) to the sum.
// Three register stages; depends on lsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsd_term (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire  [lsd_pkg::TC_W-1:0]            i_r,
    input  wire  signed [lsd_pkg::COEF_W-1:0]   i_coef,
    input  wire  [lsd_pkg::TC_W-1:0]            i_term_count,
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  lsd_pkg::t_item                      i_item,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output lsd_pkg::t_item                      o_item
);

    localparam logic signed [lsd_pkg::NUM_W-1:0] NUM_HALF =
        lsd_pkg::NUM_W'(1) << (lsd_pkg::FRAC_BITS - 1);
    localparam logic signed [lsd_pkg::MR_W-1:0] MR_HALF =
        lsd_pkg::MR_W'(1) << (lsd_pkg::RECIP_BITS - 1);

    // stage A: products
    logic                               r_a_vld;
    lsd_pkg::t_item                     r_a_item;
    logic signed [lsd_pkg::TP_W-1:0]    r_a_tp;
    logic signed [lsd_pkg::CP_W-1:0]    r_a_cp;
    // stage B: numerator and its rounding
    logic                               r_b_vld;
    lsd_pkg::t_item                     r_b_item;
    logic signed [lsd_pkg::N1_W-1:0]    r_b_n1;
    // stage C: reciprocal product, new polynomial value
    logic                               r_c_vld;
    lsd_pkg::t_item                     r_c_item;

    logic                               w_en_a, w_en_b, w_en_c;
    logic                               w_use;
    logic signed [lsd_pkg::COEF_W-1:0]  w_coef;
    logic signed [lsd_pkg::TP_W-1:0]    n_a_tp;
    logic signed [lsd_pkg::CP_W-1:0]    n_a_cp;
    logic [lsd_pkg::TC_W:0]             w_odd;
    logic [lsd_pkg::TC_W:0]             w_rm1;
    logic signed [lsd_pkg::NUM_W-1:0]   w_num;
    logic signed [lsd_pkg::NUM_W-1:0]   w_num_rnd;
    logic signed [lsd_pkg::N1_W-1:0]    w_n1;
    lsd_pkg::t_item                     n_b_item;
    logic signed [lsd_pkg::MR_W-1:0]    w_mr;
    logic signed [lsd_pkg::MR_W-1:0]    w_mr_rnd;
    lsd_pkg::t_item                     n_c_item;

    assign w_en_c  = !r_c_vld || i_ready;
    assign w_en_b  = !r_b_vld || w_en_c;
    assign w_en_a  = !r_a_vld || w_en_b;
    assign o_ready = w_en_a;
    assign o_valid = r_c_vld;
    assign o_item  = r_c_item;

    always_comb begin
        // coef_(r-1) counts only when r-1 <= term_count
        w_use  = {1'b0, i_r} <= ({1'b0, i_term_count} + (lsd_pkg::TC_W + 1)'(1));
        w_coef = w_use ? i_coef : '0;
        n_a_tp = i_item.t * i_item.p1;
        n_a_cp = w_coef * i_item.p1;
    end

    always_comb begin
        w_odd = {i_r, 1'b0} - (lsd_pkg::TC_W + 1)'(1);
        w_rm1 = {1'b0, i_r} - (lsd_pkg::TC_W + 1)'(1);
        w_num = lsd_pkg::NUM_W'(r_a_tp) * $signed({1'b0, w_odd})
              - (lsd_pkg::NUM_W'(r_a_item.p0) <<< lsd_pkg::FRAC_BITS) * $signed({1'b0, w_rm1});
        w_num_rnd = w_num + NUM_HALF;
        w_n1      = w_num_rnd[lsd_pkg::NUM_W-1:lsd_pkg::FRAC_BITS];
        n_b_item      = r_a_item;
        n_b_item.acc  = r_a_item.acc + lsd_pkg::ACC_W'(r_a_cp);
    end

    always_comb begin
        w_mr         = r_b_n1 * $signed({1'b0, lsd_pkg::recip(i_r)});
        w_mr_rnd     = w_mr + MR_HALF;
        n_c_item     = r_b_item;
        n_c_item.p0  = r_b_item.p1;
        n_c_item.p1  = w_mr_rnd[lsd_pkg::RECIP_BITS +: lsd_pkg::P_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            if (w_en_a) begin
                r_a_vld <= i_valid;
            end
            if (w_en_b) begin
                r_b_vld <= r_a_vld;
            end
            if (w_en_c) begin
                r_c_vld <= r_b_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a && i_valid) begin
            r_a_item <= i_item;
            r_a_tp   <= n_a_tp;
            r_a_cp   <= n_a_cp;
        end
        if (w_en_b && r_a_vld) begin
            r_b_item <= n_b_item;
            r_b_n1   <= w_n1;
        end
        if (w_en_c && r_b_vld) begin
            r_c_item <= n_c_item;
        end
    end

endmodule

`default_nettype wire

// ----- sv/lsd_tail.sv -----
// Last term, clamp of the shape, scale multiply, rounding and saturation; holds the output word.
// Four register stages; depends on lsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsd_tail (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire  signed [lsd_pkg::COEF_W-1:0]   i_coef,
    input  wire  [lsd_pkg::TC_W-1:0]            i_term_count,
    input  wire  [lsd_pkg::SCALE_W-1:0]         i_scale,
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  lsd_pkg::t_item                      i_item,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output logic [lsd_pkg::DEN_W-1:0]           o_density,
    output logic                                o_clamped,
    output logic                                o_saturated,
    output logic                                o_last_out
);

    localparam logic signed [lsd_pkg::ACC_W-1:0] ACC_HALF =
        lsd_pkg::ACC_W'(1) << (lsd_pkg::FRAC_BITS - 1);
    localparam logic [lsd_pkg::PRD_W:0] PRD_HALF =
        (lsd_pkg::PRD_W + 1)'(1) << (lsd_pkg::FRAC_BITS - 1);
    localparam int D_W = lsd_pkg::PRD_W + 1 - lsd_pkg::FRAC_BITS;

    logic                                r_d_vld;
    logic                                r_d_last;
    logic signed [lsd_pkg::ACC_W-1:0]    r_d_acc;
    logic signed [lsd_pkg::CP_W-1:0]     r_d_cp;
    logic                                r_e_vld;
    logic                                r_e_last;
    logic                                r_e_clamped;
    logic [lsd_pkg::SHP_W-1:0]           r_e_shape;
    logic                                r_f_vld;
    logic                                r_f_last;
    logic                                r_f_clamped;
    logic [lsd_pkg::PRD_W-1:0]           r_f_prod;
    logic                                r_g_vld;
    logic                                r_g_last;
    logic                                r_g_clamped;
    logic                                r_g_saturated;
    logic [lsd_pkg::DEN_W-1:0]           r_g_density;

    logic                                w_en_d, w_en_e, w_en_f, w_en_g;
    logic signed [lsd_pkg::COEF_W-1:0]   w_coef;
    logic signed [lsd_pkg::CP_W-1:0]     n_d_cp;
    logic signed [lsd_pkg::ACC_W-1:0]    w_sum;
    logic signed [lsd_pkg::ACC_W-1:0]    w_sum_rnd;
    logic                                n_e_clamped;
    logic [lsd_pkg::SHP_W-1:0]           n_e_shape;
    logic [lsd_pkg::PRD_W-1:0]           n_f_prod;
    logic [lsd_pkg::PRD_W:0]             w_prod_rnd;
    logic [D_W-1:0]                      w_d;
    logic                                n_g_saturated;
    logic [lsd_pkg::DEN_W-1:0]           n_g_density;

    assign w_en_g      = !r_g_vld || i_ready;
    assign w_en_f      = !r_f_vld || w_en_g;
    assign w_en_e      = !r_e_vld || w_en_f;
    assign w_en_d      = !r_d_vld || w_en_e;
    assign o_ready     = w_en_d;
    assign o_valid     = r_g_vld;
    assign o_density   = r_g_density;
    assign o_clamped   = r_g_clamped;
    assign o_saturated = r_g_saturated;
    assign o_last_out  = r_g_last;

    always_comb begin
        w_coef = ({1'b0, i_term_count} >= (lsd_pkg::TC_W + 1)'(lsd_pkg::MAX_TERMS))
               ? i_coef : '0;
        n_d_cp = w_coef * i_item.p1;
    end

    always_comb begin
        w_sum       = r_d_acc + lsd_pkg::ACC_W'(r_d_cp);
        w_sum_rnd   = w_sum + ACC_HALF;
        n_e_clamped = w_sum[lsd_pkg::ACC_W-1];
        n_e_shape   = n_e_clamped ? '0
                    : w_sum_rnd[lsd_pkg::ACC_W-2:lsd_pkg::FRAC_BITS];
    end

    assign n_f_prod = r_e_shape * lsd_pkg::PRD_W'(i_scale);

    always_comb begin
        w_prod_rnd    = {1'b0, r_f_prod} + PRD_HALF;
        w_d           = w_prod_rnd[lsd_pkg::PRD_W:lsd_pkg::FRAC_BITS];
        n_g_saturated = |w_d[D_W-1:lsd_pkg::DEN_W];
        n_g_density   = n_g_saturated ? '1 : w_d[lsd_pkg::DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
        end else begin
            if (w_en_d) begin
                r_d_vld <= i_valid;
            end
            if (w_en_e) begin
                r_e_vld <= r_d_vld;
            end
            if (w_en_f) begin
                r_f_vld <= r_e_vld;
            end
            if (w_en_g) begin
                r_g_vld <= r_f_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_d && i_valid) begin
            r_d_last <= i_item.last;
            r_d_acc  <= i_item.acc;
            r_d_cp   <= n_d_cp;
        end
        if (w_en_e && r_d_vld) begin
            r_e_last    <= r_d_last;
            r_e_clamped <= n_e_clamped;
            r_e_shape   <= n_e_shape;
        end
        if (w_en_f && r_e_vld) begin
            r_f_last    <= r_e_last;
            r_f_clamped <= r_e_clamped;
            r_f_prod    <= n_f_prod;
        end
        if (w_en_g && r_f_vld) begin
            r_g_last      <= r_f_last;
            r_g_clamped   <= r_f_clamped;
            r_g_saturated <= n_g_saturated;
            r_g_density   <= n_g_density;
        end
    end

endmodule

`default_nettype wire

// ----- sv/legendre_series_density.sv -----
// Top level: configuration registers and the chain front -> recurrence steps -> tail.
// Depends on lsd_pkg, lsd_front, lsd_term and lsd_tail.
`timescale 1ns / 1ps
`default_nettype none

// Evaluates density = scale * max(0, 1 + sum coef_r * P*_r(u)) for r = 1..min(term_count,
// MAX_TERMS) at one point u per word, with shifted Legendre polynomials built by the
// three-term recurrence. Accepts one word every cycle while the output does not stall and
// returns one word per input, in order. The path is 1 + 3 * (MAX_TERMS - 1) + 4 = 20
// register stages with six terms: one input stage, three stages per recurrence step (t*P
// product, numerator and its rounding, reciprocal product and its rounding) and four for the
// last term, the clamp, the scale multiply and the output register. Each stage stalls only
// when it holds a word and the next one cannot take it, so bubbles close up behind a stalled
// output. Write configuration only while no word is in flight.

module legendre_series_density (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_wr_en,
    input  wire  [lsd_pkg::CFG_A_W-1:0]        i_cfg_addr,
    input  wire  [lsd_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire  [lsd_pkg::U_W-1:0]            i_u_point,
    input  wire                                i_last_in,
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic [lsd_pkg::DEN_W-1:0]          o_density,
    output logic                               o_clamped,
    output logic                               o_saturated,
    output logic                               o_last_out
);

    logic [lsd_pkg::TC_W-1:0]              r_term_count;
    logic signed [lsd_pkg::COEF_W-1:0]     r_coef [lsd_pkg::NUM_COEFS];
    logic [lsd_pkg::SCALE_W-1:0]           r_scale;
    logic [lsd_pkg::CFG_A_W-1:0]           w_coef_sel;

    lsd_pkg::t_item                        w_item  [lsd_pkg::MAX_TERMS];
    logic                                  w_vld   [lsd_pkg::MAX_TERMS];
    logic                                  w_rdy   [lsd_pkg::MAX_TERMS];

    assign w_coef_sel = i_cfg_addr - lsd_pkg::CFG_A_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= '0;
            r_scale      <= lsd_pkg::SCALE_RESET;
            for (int i = 0; i < lsd_pkg::NUM_COEFS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                lsd_pkg::REG_TERM_COUNT: r_term_count <= i_cfg_wdata[lsd_pkg::TC_W-1:0];
                lsd_pkg::REG_SCALE:      r_scale      <= i_cfg_wdata[lsd_pkg::SCALE_W-1:0];
                default:                 r_coef[w_coef_sel] <= i_cfg_wdata[lsd_pkg::COEF_W-1:0];
            endcase
        end
    end

    lsd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_u_point (i_u_point),
        .i_last_in (i_last_in),
        .o_valid   (w_vld[0]),
        .i_ready   (w_rdy[0]),
        .o_item    (w_item[0])
    );

    // step i builds P_(i+2)
    for (genvar i = 0; i < lsd_pkg::MAX_TERMS - 1; i++) begin : g_term
        lsd_term u_term (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_r          (lsd_pkg::TC_W'(i + 2)),
            .i_coef       (r_coef[i]),
            .i_term_count (r_term_count),
            .i_valid      (w_vld[i]),
            .o_ready      (w_rdy[i]),
            .i_item       (w_item[i]),
            .o_valid      (w_vld[i+1]),
            .i_ready      (w_rdy[i+1]),
            .o_item       (w_item[i+1])
        );
    end

    lsd_tail u_tail (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_coef       (r_coef[lsd_pkg::MAX_TERMS-1]),
        .i_term_count (r_term_count),
        .i_scale      (r_scale),
        .i_valid      (w_vld[lsd_pkg::MAX_TERMS-1]),
        .o_ready      (w_rdy[lsd_pkg::MAX_TERMS-1]),
        .i_item       (w_item[lsd_pkg::MAX_TERMS-1]),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_density    (o_density),
        .o_clamped    (o_clamped),
        .o_saturated  (o_saturated),
        .o_last_out   (o_last_out)
    );

    a_clamp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clamped) |-> (o_density == '0))
        else $error("clamped word with nonzero density");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> (o_density == '1))
        else $error("saturated word below full scale");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_clamped && o_saturated))
        else $error("clamped and saturated together");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled while output side is free");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for legendre_series_density: streams points through the block and
// compares every density word against a bit-exact predictor of the series, clamp and scale.
// Depends on lsd_pkg and the legendre_series_density RTL.
`timescale 1ns / 1ps

module tb;

    localparam int     U_W          = lsd_pkg::U_W;
    localparam int     CFG_W        = lsd_pkg::CFG_W;
    localparam int     CFG_A_W      = lsd_pkg::CFG_A_W;
    localparam int     DEN_W        = lsd_pkg::DEN_W;
    localparam int     FRAC         = lsd_pkg::FRAC_BITS;
    localparam int     RECIP_SHIFT  = 30;
    localparam longint ONE_Q        = longint'(1) << FRAC;
    localparam longint DEN_MAX      = 64'h0000_0000_FFFF_FFFF;
    localparam int     IDLE_PCT     = 37;
    localparam int     DRAIN_CYCLES = 40;
    localparam int     CYCLE_LIMIT  = 200000;

    // coefficient registers sit right above term_count
    localparam logic [CFG_A_W-1:0] REG_COEF_1 = 3'd1;

    typedef struct packed {
        logic [DEN_W-1:0] density;
        logic             clamped;
        logic             saturated;
        logic             last;
    } density_word_t;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_A_W-1:0]   i_cfg_addr  = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    logic [U_W-1:0]       i_u_point   = '0;
    logic                 i_last_in   = 1'b0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    logic [DEN_W-1:0]     o_density;
    logic                 o_clamped;
    logic                 o_saturated;
    logic                 o_last_out;

    legendre_series_density uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_u_point   (i_u_point),
        .i_last_in   (i_last_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_density   (o_density),
        .o_clamped   (o_clamped),
        .o_saturated (o_saturated),
        .o_last_out  (o_last_out)
    );

    // predictor copy of the register file, reset values
    logic [2:0] terms_cfg = '0;
    longint     coef_cfg [1:6];
    longint     scale_cfg = ONE_Q;

    // next setting to load
    logic [2:0]       want_terms;
    logic [CFG_W-1:0] want_coef [1:6];
    logic [CFG_W-1:0] want_scale;

    density_word_t pending_densities [$];

    bit no_idle        = 1'b0;
    int mismatch_count = 0;
    int points_sent    = 0;
    int results_seen   = 0;
    int clamp_seen     = 0;
    int sat_seen       = 0;
    int settings_used  = 0;
    int cycle_count    = 0;

    initial begin
        for (int i = 1; i <= 6; i++) coef_cfg[i] = 0;
    end

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                     pending_densities.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // round half up on a right shift; >>> floors, so adding half first is enough
    function automatic longint round_up_shift(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic density_word_t predict_density(input logic [U_W-1:0] u_raw,
                                                       input logic last);
        longint        u, t, p0, p1, p2, num, acc, shape, d;
        int            k, r;
        density_word_t res;
        u = longint'(u_raw);
        if (u > ONE_Q) u = ONE_Q;
        t = 2 * u - ONE_Q;
        k = (int'(terms_cfg) > lsd_pkg::MAX_TERMS) ? lsd_pkg::MAX_TERMS : int'(terms_cfg);
        acc = ONE_Q * ONE_Q;
        p0 = ONE_Q;
        p1 = t;
        if (k >= 1) acc += coef_cfg[1] * p1;
        for (r = 2; r <= k; r++) begin
            num = longint'(2 * r - 1) * t * p1 - longint'(r - 1) * p0 * ONE_Q;
            // divide by r through round(2^30 / r)
            p2 = round_up_shift(round_up_shift(num, FRAC)
                                * (((longint'(1) << RECIP_SHIFT) + r / 2) / r), RECIP_SHIFT);
            acc += coef_cfg[r] * p2;
            p0 = p1;
            p1 = p2;
        end
        res.clamped   = (acc < 0);
        shape         = (acc < 0) ? 0 : round_up_shift(acc, FRAC);
        d             = round_up_shift(shape * scale_cfg, FRAC);
        res.saturated = (d > DEN_MAX);
        res.density   = res.saturated ? '1 : d[DEN_W-1:0];
        res.last      = last;
        return res;
    endfunction

    always @(posedge i_clk) begin : check_results
        density_word_t want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (o_clamped === 1'b1) clamp_seen++;
            if (o_saturated === 1'b1) sat_seen++;
            if (pending_densities.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected word: density %h clamped %b sat %b last %b",
                             o_density, o_clamped, o_saturated, o_last_out);
                mismatch_count++;
            end else begin
                want = pending_densities.pop_front();
                if (o_density !== want.density || o_clamped !== want.clamped ||
                    o_saturated !== want.saturated || o_last_out !== want.last) begin
                    if (mismatch_count < 10)
                        $display({"word %0d mismatch: density exp %h got %h, clamped exp %b ",
                                  "got %b, sat exp %b got %b, last exp %b got %b"},
                                 results_seen, want.density, o_density, want.clamped,
                                 o_clamped, want.saturated, o_saturated, want.last,
                                 o_last_out);
                    mismatch_count++;
                end
            end
        end
    end

    // called on a clock edge; returns on the edge the word is taken
    task automatic send_point(input logic [U_W-1:0] u, input logic last);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid   <= 1'b0;
            i_u_point <= U_W'($urandom);
            i_last_in <= 1'($urandom);
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_u_point <= u;
        i_last_in <= last;
        pending_densities.push_back(predict_density(u, last));
        points_sent++;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_densities.size() != 0) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // writes every register from want_*, only with the pipe empty
    task automatic apply_settings();
        int i;
        wait_idle();
        put_reg(lsd_pkg::REG_TERM_COUNT, CFG_W'(want_terms));
        for (i = 1; i <= 6; i++) put_reg(REG_COEF_1 + CFG_A_W'(i - 1), want_coef[i]);
        put_reg(lsd_pkg::REG_SCALE, want_scale);
        i_cfg_wr_en <= 1'b0;
        terms_cfg = want_terms;
        for (i = 1; i <= 6; i++) coef_cfg[i] = longint'(signed'(want_coef[i]));
        scale_cfg = longint'(want_scale);
        settings_used++;
    endtask

    function automatic logic [U_W-1:0] pick_point();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return U_W'(ONE_Q);
            2, 3:    return U_W'($urandom_range(65537, 131071));
            default: return U_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_coef();
        int v;
        case ($urandom_range(0, 9))
            0:       return CFG_W'($urandom);
            1:       return 24'h7F_FFFF;
            2:       return 24'h80_0000;
            default: begin
                v = $urandom_range(0, 80000);
                return CFG_W'(v - 40000);
            end
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_scale();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(0, 262144));
        endcase
    endfunction

    task automatic pick_settings();
        int i;
        want_terms = 3'($urandom_range(0, 7));
        for (i = 1; i <= 6; i++) want_coef[i] = pick_coef();
        want_scale = pick_scale();
    endtask

    task automatic clear_settings();
        int i;
        want_terms = '0;
        for (i = 1; i <= 6; i++) want_coef[i] = '0;
        want_scale = CFG_W'(ONE_Q);
    endtask

    // defaults after reset give shape one everywhere, including a point past one
    task automatic test_reset_values();
        send_point('0, 1'b0);
        send_point(U_W'(ONE_Q), 1'b1);
        send_point('1, 1'b0);
        send_point(U_W'(1), 1'b1);
    endtask

    // first term only: exact zero shape at u = 0, then a clamped negative series
    task automatic test_zero_and_clamp();
        clear_settings();
        want_terms    = 3'd1;
        want_coef[1]  = CFG_W'(ONE_Q);
        apply_settings();
        send_point('0, 1'b1);
        send_point(U_W'(ONE_Q), 1'b0);
        want_coef[1] = 24'h7F_FFFF;
        apply_settings();
        send_point('0, 1'b0);
        send_point(U_W'(ONE_Q), 1'b1);
    endtask

    // term_count of seven must behave like six
    task automatic test_term_limit();
        clear_settings();
        want_terms   = 3'd7;
        want_coef[1] = 24'h00_4000;
        want_coef[2] = 24'hFF_E000;
        want_coef[3] = 24'h00_3000;
        want_coef[4] = 24'hFF_F000;
        want_coef[5] = 24'h00_2800;
        want_coef[6] = 24'hFF_D800;
        want_scale   = 24'h00_8000;
        apply_settings();
        send_point('0, 1'b0);
        send_point(U_W'(21845), 1'b0);
        send_point(U_W'(32768), 1'b1);
        send_point(U_W'(ONE_Q), 1'b0);
        want_terms = 3'd6;
        apply_settings();
        send_point(U_W'(21845), 1'b1);
        send_point(U_W'(49151), 1'b0);
    endtask

    // extreme coefficients with full scale overflow the density
    task automatic test_saturation();
        clear_settings();
        want_terms   = 3'd2;
        want_coef[1] = 24'h80_0000;
        want_coef[2] = 24'h7F_FFFF;
        want_scale   = 24'hFF_FFFF;
        apply_settings();
        send_point('0, 1'b1);
        send_point('1, 1'b0);
        want_scale = '0;
        apply_settings();
        send_point('0, 1'b1);
    endtask

    task automatic test_random_settings();
        int phase, n;
        for (phase = 0; phase < 16; phase++) begin
            pick_settings();
            apply_settings();
            for (n = 0; n < 25; n++) send_point(pick_point(), ($urandom_range(0, 7) == 0));
        end
    endtask

    // full rate on both sides, no gaps or stalls
    task automatic test_back_to_back();
        int n;
        pick_settings();
        want_terms = 3'd6;
        apply_settings();
        no_idle = 1'b1;
        for (n = 0; n < 150; n++) send_point(pick_point(), ($urandom_range(0, 7) == 0));
        wait_idle();
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_zero_and_clamp();
        test_term_limit();
        test_saturation();
        test_random_settings();
        test_back_to_back();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        mismatch_count += pending_densities.size();
        $display("%0d points over %0d register settings, %0d words checked", points_sent,
                 settings_used + 1, results_seen);
        $display("%0d words clamped, %0d saturated, %0d mismatches", clamp_seen, sat_seen,
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
